[hdl/ovle_pkg.sv]
// Package with field widths, command codes and status codes of the ordered value list engine.
`timescale 1ns / 1ps

package ovle_pkg;

  localparam int CAPACITY_DEFAULT = 64;

  localparam int OP_W   = 3;
  localparam int VAL_W  = 32;
  localparam int STAT_W = 2;
  localparam int POS_W  = 6;
  localparam int CNT_W  = 7;

  localparam logic [OP_W-1:0] OP_APPEND = 3'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
  localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
  localparam logic [OP_W-1:0] OP_FIND   = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

  localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

  typedef logic signed [VAL_W-1:0] value_t;

endpackage

[hdl/ovle_store.sv]
// Node storage: value memory and link memory, one registered read port and one write port each.
`timescale 1ns / 1ps

module ovle_store
  import ovle_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output value_t        rd_value,
  output logic [AW-1:0] rd_next,
  input  logic          val_we,
  input  logic [AW-1:0] val_addr,
  input  value_t        val_data,
  input  logic          nxt_we,
  input  logic [AW-1:0] nxt_addr,
  input  logic [AW-1:0] nxt_data
);

  value_t        value_mem [CAPACITY];
  logic [AW-1:0] next_mem  [CAPACITY];

  always_ff @(posedge clk) begin
    if (val_we) begin
      value_mem[val_addr] <= val_data;
    end
    rd_value <= value_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (nxt_we) begin
      next_mem[nxt_addr] <= nxt_data;
    end
    rd_next <= next_mem[rd_addr];
  end

endmodule

[hdl/ovle_ctrl.sv]
// Command sequencer: list walk, node allocation, relinking and result register.
`timescale 1ns / 1ps

module ovle_ctrl
  import ovle_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT,
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   operation,
  input  value_t            first_value,
  input  value_t            second_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [POS_W-1:0]  position,
  output logic [CNT_W-1:0]  entry_count,
  output logic [AW-1:0]     rd_addr,
  input  value_t            rd_value,
  input  logic [AW-1:0]     rd_next,
  output logic              val_we,
  output logic [AW-1:0]     val_addr,
  output value_t            val_data,
  output logic              nxt_we,
  output logic [AW-1:0]     nxt_addr,
  output logic [AW-1:0]     nxt_data
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_FREE  = 3'd2;
  localparam logic [2:0] S_ALLOC = 3'd3;
  localparam logic [2:0] S_POP   = 3'd4;
  localparam logic [2:0] S_WRITE = 3'd5;
  localparam logic [2:0] S_LINK  = 3'd6;
  localparam logic [2:0] S_RESP  = 3'd7;

  localparam logic [CW-1:0] FULL_COUNT = CW'(CAPACITY);

  logic [2:0]        state;
  logic [OP_W-1:0]   cmd_op;
  value_t            cmd_a;
  value_t            cmd_b;
  logic [CW-1:0]     count;
  logic [CW-1:0]     hw;
  logic [AW-1:0]     head;
  logic [AW-1:0]     tail;
  logic [AW-1:0]     free_head;
  logic [AW-1:0]     cur;
  logic [AW-1:0]     prev;
  logic [AW-1:0]     nm;
  logic [AW-1:0]     slot;
  logic [AW-1:0]     idx;
  logic [STAT_W-1:0] res_status;
  logic [POS_W-1:0]  res_pos;
  logic              match;
  logic              last;

  assign in_ready = (state == S_IDLE);
  assign match    = (rd_value == cmd_a);
  assign last     = ((CW'(idx) + CW'(1)) == count);

  always_comb begin
    rd_addr  = cur;
    val_we   = 1'b0;
    val_addr = slot;
    val_data = (cmd_op == OP_APPEND) ? cmd_a : cmd_b;
    nxt_we   = 1'b0;
    nxt_addr = cur;
    nxt_data = slot;
    unique case (state)
      S_IDLE: begin
        rd_addr = head;
      end
      S_CHECK: begin
        rd_addr  = rd_next;
        nxt_we   = match && (cmd_op == OP_REMOVE) && (idx != '0);
        nxt_addr = prev;
        nxt_data = rd_next;
      end
      S_FREE: begin
        nxt_we   = 1'b1;
        nxt_addr = cur;
        nxt_data = free_head;
      end
      S_ALLOC: begin
        rd_addr = free_head;
      end
      S_WRITE: begin
        val_we = 1'b1;
        if (cmd_op == OP_APPEND) begin
          nxt_we   = (count != '0);
          nxt_addr = tail;
          nxt_data = slot;
        end else begin
          nxt_we   = 1'b1;
          nxt_addr = slot;
          nxt_data = nm;
        end
      end
      S_LINK: begin
        nxt_we   = 1'b1;
        nxt_addr = cur;
        nxt_data = slot;
      end
      default: begin
        rd_addr = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      hw        <= '0;
      head      <= '0;
      tail      <= '0;
      free_head <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && (state != S_RESP)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_op     <= operation;
            cmd_a      <= first_value;
            cmd_b      <= second_value;
            res_status <= ST_DONE;
            res_pos    <= '0;
            cur        <= head;
            idx        <= '0;
            unique case (operation)
              OP_APPEND: begin
                if (count == FULL_COUNT) begin
                  res_status <= ST_FULL;
                  state      <= S_RESP;
                end else begin
                  state <= S_ALLOC;
                end
              end
              OP_REMOVE, OP_INSERT, OP_FIND: begin
                if (count == '0) begin
                  res_status <= ST_MISS;
                  state      <= S_RESP;
                end else begin
                  state <= S_CHECK;
                end
              end
              OP_CLEAR: begin
                count <= '0;
                hw    <= '0;
                state <= S_RESP;
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end
        end
        S_CHECK: begin
          if (match) begin
            nm <= rd_next;
            unique case (cmd_op)
              OP_FIND: begin
                res_pos <= POS_W'(idx);
                state   <= S_RESP;
              end
              OP_REMOVE: begin
                if (idx == '0) begin
                  head <= rd_next;
                end
                if (last) begin
                  tail <= prev;
                end
                count <= count - CW'(1);
                state <= S_FREE;
              end
              OP_INSERT: begin
                if (count == FULL_COUNT) begin
                  res_status <= ST_FULL;
                  state      <= S_RESP;
                end else begin
                  state <= S_ALLOC;
                end
              end
              default: begin
                state <= S_RESP;
              end
            endcase
          end else if (last) begin
            res_status <= ST_MISS;
            state      <= S_RESP;
          end else begin
            prev <= cur;
            cur  <= rd_next;
            idx  <= idx + AW'(1);
          end
        end
        S_FREE: begin
          free_head <= cur;
          state     <= S_RESP;
        end
        S_ALLOC: begin
          if (hw < FULL_COUNT) begin
            slot  <= hw[AW-1:0];
            hw    <= hw + CW'(1);
            state <= S_WRITE;
          end else begin
            state <= S_POP;
          end
        end
        S_POP: begin
          slot      <= free_head;
          free_head <= rd_next;
          state     <= S_WRITE;
        end
        S_WRITE: begin
          if (cmd_op == OP_APPEND) begin
            if (count == '0) begin
              head <= slot;
            end
            tail  <= slot;
            count <= count + CW'(1);
            state <= S_RESP;
          end else begin
            if (cur == tail) begin
              tail <= slot;
            end
            state <= S_LINK;
          end
        end
        S_LINK: begin
          count <= count + CW'(1);
          state <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid || out_ready) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            position    <= res_pos;
            entry_count <= CNT_W'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hdl/ordered_value_list_engine_unit.sv]
// Remove, insert and find walk the list up to the first match (the whole list on a miss).
// Throughput: one request at a time; the walk follows one link per cycle through the
//   registered read port of the node memories, and a reply is held while the previous
//   reply still waits on out_ready.
// Reset: synchronous; the list is empty after reset and the node memories are not cleared.
`timescale 1ns / 1ps

module ordered_value_list_engine_unit
  import ovle_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   operation,
  input  value_t            first_value,
  input  value_t            second_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [STAT_W-1:0] status,
  output logic [POS_W-1:0]  position,
  output logic [CNT_W-1:0]  entry_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [AW-1:0] rd_addr;
  value_t        rd_value;
  logic [AW-1:0] rd_next;
  logic          val_we;
  logic [AW-1:0] val_addr;
  value_t        val_data;
  logic          nxt_we;
  logic [AW-1:0] nxt_addr;
  logic [AW-1:0] nxt_data;

  ovle_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .operation   (operation),
    .first_value (first_value),
    .second_value(second_value),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .position    (position),
    .entry_count (entry_count),
    .rd_addr     (rd_addr),
    .rd_value    (rd_value),
    .rd_next     (rd_next),
    .val_we      (val_we),
    .val_addr    (val_addr),
    .val_data    (val_data),
    .nxt_we      (nxt_we),
    .nxt_addr    (nxt_addr),
    .nxt_data    (nxt_data)
  );

  ovle_store #(
    .CAPACITY(CAPACITY)
  ) u_store (
    .clk     (clk),
    .rd_addr (rd_addr),
    .rd_value(rd_value),
    .rd_next (rd_next),
    .val_we  (val_we),
    .val_addr(val_addr),
    .val_data(val_data),
    .nxt_we  (nxt_we),
    .nxt_addr(nxt_addr),
    .nxt_data(nxt_data)
  );

endmodule
